// File: rtl/bcds_pkg.sv
// ----------------------------------------------------------------------------
// bcds_pkg
// Shared widths, constants and types for the clock divider search.
// ----------------------------------------------------------------------------
package bcds_pkg;

  localparam int FREQ_W    = 32;
  localparam int DIV_STEPS = FREQ_W;   // one quotient bit per pipeline stage
  localparam int DIVIDER_W = 9;

  localparam logic [FREQ_W-1:0] FREQ_FLOOR = 32'd1000;

  // per-word decision flags carried down the pipeline
  typedef struct packed {
    logic low;    // a frequency is under the floor
    logic zero;   // source / target is zero
    logic sat;    // source / target reaches the largest divider
  } bcds_flags_t;

endpackage

// File: rtl/bcds_div_pipe.sv
// ----------------------------------------------------------------------------
// bcds_div_pipe
// Restoring unsigned divider, one quotient bit per register stage, with a
// sideband bus that travels alongside each word.
// ----------------------------------------------------------------------------
module bcds_div_pipe #(
  parameter int DVW = 32,
  parameter int SW  = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [bcds_pkg::FREQ_W-1:0] dividend_i,
  input  logic [DVW-1:0]              divisor_i,
  input  logic [SW-1:0]               side_i,
  output logic                        valid_o,
  output logic [bcds_pkg::FREQ_W-1:0] quotient_o,
  output logic [SW-1:0]               side_o
);
  import bcds_pkg::*;

  logic [DIV_STEPS-1:0] valid_q;
  logic [DVW-1:0]       rem_q  [DIV_STEPS];
  logic [FREQ_W-1:0]    quo_q  [DIV_STEPS];
  logic [DVW-1:0]       dvs_q  [DIV_STEPS];
  logic [SW-1:0]        side_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic              val_p;
    logic [DVW-1:0]    rem_p;
    logic [DVW-1:0]    dvs_p;
    logic [FREQ_W-1:0] quo_p;
    logic [SW-1:0]     side_p;
    logic [DVW:0]      trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign val_p  = valid_i;
      assign rem_p  = '0;
      assign dvs_p  = divisor_i;
      assign quo_p  = dividend_i;
      assign side_p = side_i;
    end else begin : g_next
      assign val_p  = valid_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign dvs_p  = dvs_q[k-1];
      assign quo_p  = quo_q[k-1];
      assign side_p = side_q[k-1];
    end

    // shift in the next dividend bit and try the subtraction
    assign trial = {rem_p, quo_p[FREQ_W-1]};
    assign ge    = (trial >= {1'b0, dvs_p});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= val_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? DVW'(trial - {1'b0, dvs_p}) : trial[DVW-1:0];
        quo_q[k]  <= {quo_p[FREQ_W-2:0], ge};
        dvs_q[k]  <= dvs_p;
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o    = valid_q[DIV_STEPS-1];
  assign quotient_o = quo_q[DIV_STEPS-1];
  assign side_o     = side_q[DIV_STEPS-1];

endmodule

// File: rtl/best_clock_divider_search_top.sv
// ----------------------------------------------------------------------------
// best_clock_divider_search_top
// Picks 1..MAX_DIVIDER, truncated quotient nearest target; 1 below the floor.
// ----------------------------------------------------------------------------
// A request word (source_freq_i, target_freq_i) enters on in_valid_i/in_ready_o
// and exactly one result word (divider_o) leaves on out_valid_o/out_ready_i,
// in request order. Since the quotient falls as the divider grows, only two
// candidates matter: d0 = source/target (clamped) and d0+1; the smallest
// divider sharing d0's quotient is source/(q0+1)+1.
// Four 32-stage dividers in three steps in series do this work: source/target,
// then source/d0 and source/(d0+1) side by side, then source/(q0+1).
// One word is taken every cycle while the output is free or being taken.
// Reset empties the pipeline; no other state is kept.
// When the receiver stalls a held result, the whole pipeline freezes and
// in_ready_o drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module best_clock_divider_search_top #(
  parameter int MAX_DIVIDER = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bcds_pkg::FREQ_W-1:0]    source_freq_i,
  input  logic [bcds_pkg::FREQ_W-1:0]    target_freq_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bcds_pkg::DIVIDER_W-1:0] divider_o
);
  import bcds_pkg::*;

  localparam int DW = $clog2(MAX_DIVIDER + 2);
  localparam int S1_W = 2 * FREQ_W + 1;
  localparam int SA_W = 2 * FREQ_W + $bits(bcds_flags_t);
  localparam int SC_W = $bits(bcds_flags_t) + DW + 1;

  logic en;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // first division: source / target
  logic              v1;
  logic [FREQ_W-1:0] quo1;
  logic [S1_W-1:0]   side1;
  logic              low_in;

  assign low_in = (source_freq_i < FREQ_FLOOR) || (target_freq_i < FREQ_FLOOR);

  bcds_div_pipe #(.DVW(FREQ_W), .SW(S1_W)) u_div_ratio (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .dividend_i(source_freq_i), .divisor_i(target_freq_i),
    .side_i({source_freq_i, target_freq_i, low_in}),
    .valid_o(v1), .quotient_o(quo1), .side_o(side1)
  );

  // clamp to a divider and form its neighbor
  logic              v2_q;
  logic [FREQ_W-1:0] src2_q, tgt2_q;
  bcds_flags_t       flags2_q;
  logic [DW-1:0]     d0_q, d1_q;
  bcds_flags_t       flags2_d;
  logic [DW-1:0]     d0_d;

  always_comb begin
    flags2_d.low  = side1[0];
    flags2_d.zero = (quo1 == '0);
    flags2_d.sat  = (quo1 >= FREQ_W'(MAX_DIVIDER));
    if (flags2_d.zero) begin
      d0_d = DW'(1);
    end else if (flags2_d.sat) begin
      d0_d = DW'(MAX_DIVIDER);
    end else begin
      d0_d = quo1[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      src2_q   <= side1[S1_W-1 -: FREQ_W];
      tgt2_q   <= side1[FREQ_W:1];
      flags2_q <= flags2_d;
      d0_q     <= d0_d;
      d1_q     <= d0_d + DW'(1);
    end
  end

  // second division: source / d0 and source / (d0 + 1)
  logic              v3;
  logic [FREQ_W-1:0] q0, q1;
  logic [SA_W-1:0]   side_a;
  logic [DW-1:0]     d1_b;
  logic              v3_b;

  bcds_div_pipe #(.DVW(DW), .SW(SA_W)) u_div_lo (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q),
    .dividend_i(src2_q), .divisor_i(d0_q),
    .side_i({src2_q, tgt2_q, flags2_q}),
    .valid_o(v3), .quotient_o(q0), .side_o(side_a)
  );

  bcds_div_pipe #(.DVW(DW), .SW(DW)) u_div_hi (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q),
    .dividend_i(src2_q), .divisor_i(d1_q),
    .side_i(d1_q),
    .valid_o(v3_b), .quotient_o(q1), .side_o(d1_b)
  );

  // compare the two errors, smaller divider wins ties
  logic              v4_q;
  logic [FREQ_W-1:0] src4_q;
  bcds_flags_t       flags4_q;
  logic [DW-1:0]     d1_4_q;
  logic [FREQ_W:0]   qnext_q;
  logic              pick_a_q;
  logic [FREQ_W-1:0] tgt3;
  bcds_flags_t       flags3;

  assign tgt3   = side_a[$bits(bcds_flags_t) +: FREQ_W];
  assign flags3 = side_a[$bits(bcds_flags_t)-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3 && v3_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      src4_q   <= side_a[SA_W-1 -: FREQ_W];
      flags4_q <= flags3;
      d1_4_q   <= d1_b;
      qnext_q  <= {1'b0, q0} + (FREQ_W+1)'(1);
      pick_a_q <= (q0 - tgt3) <= (tgt3 - q1);
    end
  end

  // third division: first divider sharing quotient q0
  logic              v5;
  logic [FREQ_W-1:0] quo5;
  logic [SC_W-1:0]   side5;
  bcds_flags_t       flags5;
  logic [DW-1:0]     d1_5;
  logic              pick_a5;
  logic [FREQ_W-1:0] sel_d;

  bcds_div_pipe #(.DVW(FREQ_W + 1), .SW(SC_W)) u_div_first (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q),
    .dividend_i(src4_q), .divisor_i(qnext_q),
    .side_i({flags4_q, d1_4_q, pick_a_q}),
    .valid_o(v5), .quotient_o(quo5), .side_o(side5)
  );

  assign flags5  = side5[SC_W-1 -: $bits(bcds_flags_t)];
  assign d1_5    = side5[DW:1];
  assign pick_a5 = side5[0];

  always_comb begin
    if (flags5.low || flags5.zero) begin
      sel_d = FREQ_W'(1);
    end else if (flags5.sat || pick_a5) begin
      sel_d = quo5 + FREQ_W'(1);
    end else begin
      sel_d = FREQ_W'(d1_5);
    end
  end

  logic              out_valid_q;
  logic [FREQ_W-1:0] sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v5;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sel_q <= sel_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign divider_o   = sel_q[DIVIDER_W-1:0];

`ifndef SYNTHESIS
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (sel_q >= FREQ_W'(1)) && (sel_q <= FREQ_W'(MAX_DIVIDER)))
    else $error("divider out of range");

  a_lo_side_above_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3 && !flags3.low && !flags3.zero) |-> (q0 >= tgt3))
    else $error("lower candidate quotient below target");

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3 == v3_b)
    else $error("parallel dividers out of step");
`endif

endmodule
